@@ rtl/fta_pkg.sv @@
// Shared types, constants and index packing for the two-electron Fock accumulator.
`default_nettype none
package fta_pkg;

  localparam int DEFAULT_BASIS_SIZE = 128;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 48;
  localparam int DELTA_W = 44;  // |v*d| <= 2^63, shifted by at least 22
  localparam int PACK_W  = 2*IDX_W + 1;

  localparam logic [1:0] OP_WR_DENS = 2'd0;
  localparam logic [1:0] OP_APPLY   = 2'd1;
  localparam logic [1:0] OP_RD_FOCK = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  typedef struct packed {
    logic       coulomb;
    logic       unres;
    logic [4:0] shift;
  } term_ctl_t;

  // packed lower-triangle position of (a,b), order-free
  function automatic logic [PACK_W-1:0] tri_pack(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0]    hi;
    logic [IDX_W-1:0]    lo;
    logic [IDX_W:0]      hi1;
    logic [PACK_W:0]     m;
    hi  = (a > b) ? a : b;
    lo  = (a > b) ? b : a;
    hi1 = (IDX_W+1)'(hi) + (IDX_W+1)'(1);
    m   = (PACK_W+1)'(hi) * (PACK_W+1)'(hi1);
    return m[PACK_W:1] + PACK_W'(lo);
  endfunction

endpackage
`default_nettype wire

@@ rtl/fock_two_electron_accumulate.sv @@
// Top level: density and Fock stores, integral sequencer and read path.
// Usage:
//   in_* carries one command beat (valid/ready): density write, integral,
//   Fock read or Fock clear. out_* returns one beat per Fock read only.
//   cfg_wr_en/cfg_wr_data set the unrestricted flag; write only when idle.
// Steps per command, from acceptance to ready again:
//   density write at acceptance; Fock read through the Fock read and output registers;
//   integral in 6 slots, each one pack, one density/Fock read, one multiply,
//   one scale and one saturating write;
//   clear writes all BASIS_SIZE*(BASIS_SIZE+1)/2 entries (8256 at 128), one entry a cycle.
// One command is in work at a time; the slots run in turn through the one
// read port and one write port of each Fock memory and set the integral rate.
// Reset runs the same clearing pass with in_ready low.
// A held result does not block density writes, integrals or clears; a
// second read waits until the held beat is taken.
`default_nettype none
module fock_two_electron_accumulate
  import fta_pkg::*;
#(
  parameter int BASIS_SIZE = DEFAULT_BASIS_SIZE
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_opcode,
  input  wire logic                      in_matrix_select,
  input  wire logic [IDX_W-1:0]          in_index_a,
  input  wire logic [IDX_W-1:0]          in_index_b,
  input  wire logic [IDX_W-1:0]          in_index_c,
  input  wire logic [IDX_W-1:0]          in_index_d,
  input  wire logic signed [VAL_W-1:0]   in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [ACC_W-1:0]        out_fock_value
);

  localparam int TRI = (BASIS_SIZE * (BASIS_SIZE + 1)) / 2;
  localparam int AW  = (TRI > 1) ? $clog2(TRI) : 1;

  typedef enum logic [7:0] {
    ST_CLR  = 8'b00000001,
    ST_IDLE = 8'b00000010,
    ST_ADDR = 8'b00000100,
    ST_RD   = 8'b00001000,
    ST_MUL  = 8'b00010000,
    ST_SHF  = 8'b00100000,
    ST_UPD  = 8'b01000000,
    ST_FRD  = 8'b10000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     unres_r;
  logic [AW-1:0]            clr_cnt_r;
  logic [2:0]               slot_r;
  logic [IDX_W-1:0]         i_r, j_r, k_r, l_r;
  logic [1:0]               h_r;
  logic signed [VAL_W-1:0]  val_r;
  logic                     mode_r;
  logic [AW-1:0]            tgt_r, src_r;
  logic                     rd_ok_r, rd_half_r, rd_sel_r;
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  out_val_r;

  // memories
  logic signed [VAL_W-1:0]  dens_a_mem [TRI];
  logic signed [VAL_W-1:0]  dens_b_mem [TRI];
  logic signed [ACC_W-1:0]  fock_a_mem [TRI];
  logic signed [ACC_W-1:0]  fock_b_mem [TRI];
  logic signed [VAL_W-1:0]  dens_a_rd_r, dens_b_rd_r;
  logic signed [ACC_W-1:0]  fock_a_rd_r, fock_b_rd_r;

  logic                     accept;
  logic                     ab_ok, cd_ok;
  logic [AW-1:0]            in_addr;
  logic [IDX_W-1:0]         p1, p2, p3, p4, s1, s2, s3, s4;
  logic                     swap;
  logic [1:0]               h_nxt;

  logic [IDX_W-1:0]         ta, tb, sa, sb;
  logic                     coulomb;
  term_ctl_t                ctl;
  logic signed [DELTA_W-1:0] delta_a_r, delta_b_r, delta_b_sel;

  logic                     f_re;
  logic [AW-1:0]            f_raddr;
  logic                     fa_we, fb_we;
  logic [AW-1:0]            f_waddr;
  logic signed [ACC_W-1:0]  fa_wdata, fb_wdata;
  logic                     d_we;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ab_ok    = (32'(in_index_a) < BASIS_SIZE) && (32'(in_index_b) < BASIS_SIZE);
  assign cd_ok    = (32'(in_index_c) < BASIS_SIZE) && (32'(in_index_d) < BASIS_SIZE);
  assign in_addr  = AW'(tri_pack(in_index_a, in_index_b));

  // canonical index order and halving count
  always_comb begin
    p1 = (in_index_a > in_index_b) ? in_index_a : in_index_b;
    p2 = (in_index_a > in_index_b) ? in_index_b : in_index_a;
    p3 = (in_index_c > in_index_d) ? in_index_c : in_index_d;
    p4 = (in_index_c > in_index_d) ? in_index_d : in_index_c;
    swap = (p1 < p3) || ((p1 == p3) && (p2 < p4));
    s1 = swap ? p3 : p1;
    s2 = swap ? p4 : p2;
    s3 = swap ? p1 : p3;
    s4 = swap ? p2 : p4;
    h_nxt = 2'(s1 == s2) + 2'(s3 == s4) + 2'((s1 == s3) && (s2 == s4));
  end

  // per-slot target and source pairs
  always_comb begin
    coulomb = 1'b0;
    case (slot_r)
      3'd0: begin ta = i_r; tb = j_r; sa = k_r; sb = l_r; coulomb = 1'b1; end
      3'd1: begin ta = k_r; tb = l_r; sa = i_r; sb = j_r; coulomb = 1'b1; end
      3'd2: begin ta = i_r; tb = k_r; sa = j_r; sb = l_r; end
      3'd3: begin ta = i_r; tb = l_r; sa = j_r; sb = k_r; end
      3'd4: begin ta = j_r; tb = k_r; sa = i_r; sb = l_r; end
      3'd5: begin ta = j_r; tb = l_r; sa = i_r; sb = k_r; end
      default: begin ta = j_r; tb = l_r; sa = i_r; sb = k_r; end
    endcase
  end

  always_comb begin
    ctl.coulomb = coulomb;
    ctl.unres   = mode_r;
    if (coulomb)
      ctl.shift = 5'd22 + 5'(h_r);
    else if (mode_r)
      ctl.shift = 5'd23 + 5'(h_r);
    else
      ctl.shift = 5'd24 + 5'(h_r);
  end

  fta_term u_term (
    .clk       (clk),
    .mul_en    (state_r == ST_MUL),
    .shf_en    (state_r == ST_SHF),
    .ctl       (ctl),
    .value     (val_r),
    .dens_a    (dens_a_rd_r),
    .dens_b    (dens_b_rd_r),
    .delta_a_r (delta_a_r),
    .delta_b_r (delta_b_r)
  );

  assign delta_b_sel = coulomb ? delta_a_r : delta_b_r;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                       input logic signed [DELTA_W-1:0] dl);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(dl);
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

  // Fock port control
  always_comb begin
    f_re     = 1'b0;
    f_raddr  = tgt_r;
    fa_we    = 1'b0;
    fb_we    = 1'b0;
    f_waddr  = tgt_r;
    fa_wdata = sat_add(fock_a_rd_r, delta_a_r);
    fb_wdata = sat_add(fock_b_rd_r, delta_b_sel);
    if (state_r == ST_CLR) begin
      fa_we    = 1'b1;
      fb_we    = 1'b1;
      f_waddr  = clr_cnt_r;
      fa_wdata = '0;
      fb_wdata = '0;
    end else if (state_r == ST_UPD) begin
      fa_we = 1'b1;
      fb_we = mode_r;
    end
    if (state_r == ST_RD) begin
      f_re = 1'b1;
    end else if (accept && in_opcode == OP_RD_FOCK && ab_ok) begin
      f_re    = 1'b1;
      f_raddr = in_addr;
    end
  end

  assign d_we = accept && (in_opcode == OP_WR_DENS) && ab_ok;

  always_ff @(posedge clk) begin
    if (d_we && !in_matrix_select) dens_a_mem[in_addr] <= in_value;
    if (d_we &&  in_matrix_select) dens_b_mem[in_addr] <= in_value;
    if (state_r == ST_RD) begin
      dens_a_rd_r <= dens_a_mem[src_r];
      dens_b_rd_r <= dens_b_mem[src_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fa_we) fock_a_mem[f_waddr] <= fa_wdata;
    if (fb_we) fock_b_mem[f_waddr] <= fb_wdata;
    if (f_re) begin
      fock_a_rd_r <= fock_a_mem[f_raddr];
      fock_b_rd_r <= fock_b_mem[f_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_cnt_r == AW'(TRI - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_APPLY:   if (ab_ok && cd_ok) state_nxt = ST_ADDR;
            OP_RD_FOCK: state_nxt = ST_FRD;
            OP_CLEAR:   state_nxt = ST_CLR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADDR: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SHF;
      ST_SHF:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (slot_r == 3'd5) ? ST_IDLE : ST_ADDR;
      ST_FRD:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      unres_r     <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) unres_r <= cfg_wr_data;
      if (state_r == ST_CLR)
        clr_cnt_r <= (clr_cnt_r == AW'(TRI - 1)) ? '0 : clr_cnt_r + AW'(1);
      if (state_r == ST_IDLE) slot_r <= '0;
      else if (state_r == ST_UPD) slot_r <= slot_r + 3'd1;
      if (state_r == ST_FRD && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r       <= s1;
      j_r       <= s2;
      k_r       <= s3;
      l_r       <= s4;
      h_r       <= h_nxt;
      val_r     <= in_value;
      mode_r    <= unres_r;
      rd_ok_r   <= ab_ok;
      rd_half_r <= (in_index_a != in_index_b);
      rd_sel_r  <= in_matrix_select;
    end
    if (state_r == ST_ADDR) begin
      tgt_r <= AW'(tri_pack(ta, tb));
      src_r <= AW'(tri_pack(sa, sb));
    end
    if (state_r == ST_FRD && (!out_valid_r || out_ready)) begin
      if (!rd_ok_r)
        out_val_r <= '0;
      else if (rd_half_r)
        out_val_r <= (rd_sel_r ? fock_b_rd_r : fock_a_rd_r) >>> 1;
      else
        out_val_r <= rd_sel_r ? fock_b_rd_r : fock_a_rd_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fock_value = out_val_r;

endmodule
`default_nettype wire

@@ rtl/fta_term.sv @@
// Two-stage term unit: density times integral, then floor scaling and sign.
`default_nettype none
module fta_term
  import fta_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      mul_en,
  input  wire logic                      shf_en,
  input  wire term_ctl_t                 ctl,
  input  wire logic signed [VAL_W-1:0]   value,
  input  wire logic signed [VAL_W-1:0]   dens_a,
  input  wire logic signed [VAL_W-1:0]   dens_b,
  output logic signed [DELTA_W-1:0]      delta_a_r,
  output logic signed [DELTA_W-1:0]      delta_b_r
);

  logic signed [VAL_W:0]     d_a;
  logic signed [2*VAL_W:0]   prod_a_r;
  logic signed [2*VAL_W:0]   prod_b_r;
  logic signed [2*VAL_W:0]   sh_a;
  logic signed [2*VAL_W:0]   sh_b;
  logic signed [DELTA_W-1:0] delta_a_nxt;
  logic signed [DELTA_W-1:0] delta_b_nxt;

  // unrestricted Coulomb sees the total density
  assign d_a = (ctl.coulomb && ctl.unres) ? ((VAL_W+1)'(dens_a) + (VAL_W+1)'(dens_b))
                                          : (VAL_W+1)'(dens_a);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_a_r <= (2*VAL_W+1)'(value) * (2*VAL_W+1)'(d_a);
      prod_b_r <= (2*VAL_W+1)'(value) * (2*VAL_W+1)'(dens_b);
    end
  end

  // arithmetic shift floors, matching round toward minus infinity
  assign sh_a = prod_a_r >>> ctl.shift;
  assign sh_b = prod_b_r >>> ctl.shift;

  always_comb begin
    delta_a_nxt = sh_a[DELTA_W-1:0];
    delta_b_nxt = sh_b[DELTA_W-1:0];
    if (!ctl.coulomb) begin
      delta_a_nxt = -sh_a[DELTA_W-1:0];
      delta_b_nxt = -sh_b[DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (shf_en) begin
      delta_a_r <= delta_a_nxt;
      delta_b_r <= delta_b_nxt;
    end
  end

endmodule
`default_nettype wire
